// ===== hdl/lkv_pkg.sv =====
package lkv_pkg;

  // Fixed field widths of the request and result beats.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int OCC_W = 5;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request commands.
  localparam logic [1:0] CMD_GET      = 2'd0;
  localparam logic [1:0] CMD_PUT      = 2'd1;
  localparam logic [1:0] CMD_REMOVE   = 2'd2;
  localparam logic [1:0] CMD_CONTAINS = 2'd3;

  // Chain operations broadcast to every cell during the update cycle.
  localparam logic [1:0] OP_HOLD    = 2'd0;
  localparam logic [1:0] OP_PROMOTE = 2'd1;
  localparam logic [1:0] OP_INSERT  = 2'd2;
  localparam logic [1:0] OP_REMOVE  = 2'd3;

  // One stored entry as it moves between neighboring cells.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Control broadcast from the sequencer to the chain.
  typedef struct packed {
    logic [1:0] op;
    logic       evict;
    logic       capture;
  } cell_ctl_t;

endpackage

// ===== hdl/lkv_cell.sv =====
module lkv_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lkv_pkg::cell_ctl_t          ctl,
  input  lkv_pkg::entry_t             left_in,
  input  lkv_pkg::entry_t             right_in,
  input  logic [lkv_pkg::KEY_W-1:0]   cmp_key,
  input  logic                        seen_in,
  output logic                        seen_out,
  output logic                        match_now,
  output logic                        match_q,
  output lkv_pkg::entry_t             ent_out
);
  import lkv_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic             match_r, match_nxt;

  // Associative compare against the key of the beat being accepted.
  assign match_now = valid_r && (key_r == cmp_key);
  assign match_q   = match_r;

  // A hit at this cell or any more recent cell.
  assign seen_out = seen_in | match_r;

  assign ent_out.valid = valid_r;
  assign ent_out.key   = key_r;
  assign ent_out.value = value_r;

  // Each cell either holds, takes its more recent neighbor or takes its
  // less recent neighbor. The chain stays ordered by recency.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    match_nxt = ctl.capture ? match_now : match_r;
    case (ctl.op)
      OP_PROMOTE: begin
        // Cells up to and including the hit shift one place back.
        if (!seen_in) begin
          valid_nxt = left_in.valid;
          key_nxt   = left_in.key;
          value_nxt = left_in.value;
        end
      end
      OP_INSERT: begin
        // On eviction the last valid entry falls off; empty cells hold.
        if (!ctl.evict || valid_r) begin
          valid_nxt = left_in.valid;
          key_nxt   = left_in.key;
          value_nxt = left_in.value;
        end
      end
      OP_REMOVE: begin
        // The hit and everything behind it close the gap.
        if (seen_in || match_r) begin
          valid_nxt = right_in.valid;
          key_nxt   = right_in.key;
          value_nxt = right_in.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// Channel   Direction  Handshake            Payload
// in_       request    in_valid / in_stall  in_command, in_key, in_value
// out_      result     out_valid/out_stall  out_hit, out_read_value, out_occupancy
// cfg_      write      cfg_valid/cfg_ready  cfg_capacity
//
// The key is compared against every cell at the accepting edge, and the cell chain
// shifts when the update state completes.
// The chain update is the single shared step, so one request is in flight.
// The update waits while a finished result is held with out_stall high.
// Reset (rst_n low, synchronous) empties the cache and sets capacity to 16.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [lkv_pkg::KEY_W-1:0]   in_key,
  input  logic [lkv_pkg::VAL_W-1:0]   in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [lkv_pkg::VAL_W-1:0]   out_read_value,
  output logic [lkv_pkg::OCC_W-1:0]   out_occupancy,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_capacity
);
  import lkv_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic             state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             hit_r, hit_nxt;
  logic [VAL_W-1:0] hitval_r, hitval_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [VAL_W-1:0] out_rd_r, out_rd_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic             accept;
  logic             upd_go;
  logic             evict;
  logic             cap_zero;
  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] cap_ext;
  cell_ctl_t        ctl;
  entry_t           head;
  entry_t           tail;
  entry_t           ent    [ENTRIES];
  logic             seen   [ENTRIES+1];
  logic [ENTRIES-1:0] match_now;
  logic [ENTRIES-1:0] match_q;
  logic [ENTRIES-1:0] valid_vec;
  logic [VAL_W-1:0] hit_sel;

  // Handshakes.
  assign in_stall  = (state_r == ST_UPD);
  assign accept    = in_valid && !in_stall;
  assign upd_go    = (state_r == ST_UPD) && !(out_valid_r && out_stall);
  assign cfg_ready = (state_r == ST_IDLE);

  // Effective limit is the smaller of capacity and the number of cells.
  assign cap_ext  = LIM_W'(cap_r);
  assign lim      = (cap_ext < LIM_W'(ENTRIES)) ? cap_ext : LIM_W'(ENTRIES);
  assign cap_zero = (cap_r == '0);
  assign evict    = (LIM_W'(count_r) >= lim);

  // The entry entering the front of the chain on promote or insert.
  assign head.valid = 1'b1;
  assign head.key   = key_r;
  assign head.value = (cmd_r == CMD_PUT) ? val_r : hitval_r;

  assign tail = '0;

  // Cell chain, most recent entry in cell zero.
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_in   ((i == 0) ? head : ent[(i == 0) ? 0 : i-1]),
      .right_in  ((i == ENTRIES-1) ? tail : ent[(i == ENTRIES-1) ? i : i+1]),
      .cmp_key   (in_key),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .match_now (match_now[i]),
      .match_q   (match_q[i]),
      .ent_out   (ent[i])
    );
    assign valid_vec[i] = ent[i].valid;
  end

  // Value of the matching cell; keys are unique so at most one contributes.
  always_comb begin
    hit_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_sel = hit_sel | (match_now[i] ? ent[i].value : '0);
    end
  end

  // Chain operation for the update cycle.
  always_comb begin
    ctl.capture = accept;
    ctl.evict   = evict;
    ctl.op      = OP_HOLD;
    count_nxt   = count_r;
    if (upd_go) begin
      case (cmd_r)
        CMD_GET: begin
          if (hit_r) ctl.op = OP_PROMOTE;
        end
        CMD_PUT: begin
          if (!cap_zero) begin
            if (hit_r) begin
              ctl.op = OP_PROMOTE;
            end else begin
              ctl.op = OP_INSERT;
              if (!evict) count_nxt = count_r + CNT_W'(1);
            end
          end
        end
        CMD_REMOVE: begin
          if (hit_r) begin
            ctl.op    = OP_REMOVE;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request capture, result register and configuration.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    hit_nxt       = hit_r;
    hitval_nxt    = hitval_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_rd_nxt    = out_rd_r;
    out_occ_nxt   = out_occ_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cfg_valid && cfg_ready) cap_nxt = cfg_capacity;

    if (accept) begin
      state_nxt  = ST_UPD;
      cmd_nxt    = in_command;
      key_nxt    = in_key;
      val_nxt    = in_value;
      hit_nxt    = |match_now;
      hitval_nxt = hit_sel;
    end

    if (upd_go) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      out_hit_nxt   = hit_r;
      out_rd_nxt    = (cmd_r == CMD_GET && hit_r) ? hitval_r : '0;
      out_occ_nxt   = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    hit_r     <= hit_nxt;
    hitval_r  <= hitval_nxt;
    out_hit_r <= out_hit_nxt;
    out_rd_r  <= out_rd_nxt;
    out_occ_r <= out_occ_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_rd_r;
  assign out_occupancy  = out_occ_r;

  // Stored keys stay unique, so a lookup never matches two cells.
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_q))
    else $error("more than one cell matched the key");

  // The count tracks the number of valid cells.
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(count_r))
    else $error("entry count disagrees with valid cells");

  // Valid cells are packed at the most recent end of the chain.
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + ENTRIES'(1)) & valid_vec) == '0)
    else $error("gap in the valid cells");

  // Every accepted request produces a result after its update cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_valid_r && (state_r == ST_IDLE))
    else $error("update did not produce a result");

endmodule

// ===== tb/tb.sv =====
module tb;
  import lkv_pkg::*;

  localparam int ENTRIES = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 120;
  localparam int KEY_POOL = 32;

  // One result beat as the cache reports it.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic [OCC_W-1:0] occupancy;
  } lookup_result_t;

  // One row of the directed table: either a capacity write or a request.
  typedef struct packed {
    logic             is_cfg;
    logic [CAP_W-1:0] cap;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic [OCC_W-1:0] occupancy;
  } step_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_command;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic             out_stall;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic [OCC_W-1:0] out_occupancy;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_capacity;

  // Shadow copy of the cache contents and recency order.
  logic [KEY_W-1:0] shadow_key [ENTRIES];
  logic [VAL_W-1:0] shadow_value [ENTRIES];
  bit               shadow_valid [ENTRIES];
  logic [3:0]       shadow_rank [ENTRIES];
  logic [OCC_W-1:0] shadow_count;
  logic [CAP_W-1:0] shadow_capacity;

  lookup_result_t   pending_results [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int               mismatch_count;
  int               quiet_cycles;
  int               gap_pct;
  int               stall_pct;
  bit               hold_request;

  // Directed rows; typed results are only given where they are obvious.
  step_t directed_steps [22] = '{
    '{1'b0, 5'd0,  CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_CONTAINS, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_REMOVE,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_PUT,      32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 5'd1},
    '{1'b0, 5'd0,  CMD_PUT,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd2},
    '{1'b0, 5'd0,  CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
      32'hFFFF_FFFF, 5'd2},
    '{1'b0, 5'd0,  CMD_CONTAINS, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 5'd2},
    '{1'b0, 5'd0,  CMD_PUT,      32'h0000_0000, 32'h5A5A_A5A5, 1'b1, 1'b1, 32'h0, 5'd2},
    '{1'b1, 5'd2,  CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_PUT,      32'h0000_0007, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_GET,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_REMOVE,   32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_REMOVE,   32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b1, 5'd0,  CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_PUT,      32'h0000_0009, 32'h0000_0003, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_PUT,      32'h0000_0000, 32'h0000_0004, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b1, 5'd31, CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_REMOVE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b0, 5'd0,  CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{1'b1, 5'd16, CMD_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0}
  };

  lru_key_value_cache uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_occupancy  (out_occupancy),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Move slot s to the front; entries ahead of it age by one.
  function automatic void make_most_recent(int s);
    logic [3:0] old_rank;
    old_rank = shadow_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && i != s && shadow_rank[i] < old_rank)
        shadow_rank[i]++;
    shadow_rank[s] = '0;
  endfunction

  // Invalidate slot s; entries behind it move up one place.
  function automatic void invalidate_slot(int s);
    logic [3:0] old_rank;
    old_rank = shadow_rank[s];
    shadow_valid[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && shadow_rank[i] > old_rank)
        shadow_rank[i]--;
    if (shadow_count > 0)
      shadow_count--;
  endfunction

  // Apply one request to the shadow cache and return the result it should produce.
  function automatic lookup_result_t lru_lookup(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                                logic [VAL_W-1:0] value);
    lookup_result_t res;
    int match;
    int victim;
    int slot;
    int limit;
    match = -1;
    victim = -1;
    slot = -1;
    res = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (match < 0 && shadow_valid[i] && shadow_key[i] == key)
        match = i;
    limit = (shadow_capacity < ENTRIES) ? int'(shadow_capacity) : ENTRIES;
    case (cmd)
      CMD_GET: begin
        if (match >= 0) begin
          res.read_value = shadow_value[match];
          make_most_recent(match);
        end
      end
      CMD_PUT: begin
        if (limit != 0) begin
          if (match >= 0) begin
            shadow_value[match] = value;
            make_most_recent(match);
          end else begin
            // A full cache gives up its least recent entry first.
            if (int'(shadow_count) >= limit) begin
              for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                  victim = i;
              if (victim >= 0)
                invalidate_slot(victim);
            end
            for (int i = 0; i < ENTRIES; i++)
              if (slot < 0 && !shadow_valid[i])
                slot = i;
            if (slot >= 0) begin
              for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i])
                  shadow_rank[i]++;
              shadow_valid[slot] = 1'b1;
              shadow_key[slot] = key;
              shadow_value[slot] = value;
              shadow_rank[slot] = '0;
              shadow_count++;
            end
          end
        end
      end
      CMD_REMOVE: begin
        if (match >= 0)
          invalidate_slot(match);
      end
      default: begin
      end
    endcase
    res.hit = (match >= 0);
    res.occupancy = shadow_count;
    return res;
  endfunction

  // Offer one request beat, optionally after a gap, and queue its result once accepted.
  task automatic send_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value, input bit typed,
                              input lookup_result_t typed_res);
    lookup_result_t predicted;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_command = cmd;
    in_key = key;
    in_value = value;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = lru_lookup(cmd, key, value);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Drain all outstanding results, then write the capacity register.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid = 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    @(negedge clk);
    cfg_capacity = cap;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_capacity = cap;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random traffic over a pool of keys, so that hits, evictions and removes are common.
  task automatic run_traffic(input int count, input int pool_size);
    logic [1:0] cmd;
    logic [KEY_W-1:0] key;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        cmd = CMD_PUT;
      else if (pick < 65)
        cmd = CMD_GET;
      else if (pick < 80)
        cmd = CMD_REMOVE;
      else
        cmd = CMD_CONTAINS;
      if ($urandom_range(0, 99) < 88)
        key = key_pool[$urandom_range(0, pool_size - 1)];
      else
        key = $urandom;
      send_request(cmd, key, $urandom, 1'b0, '0);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
        hold_request = 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: hit %0b value %h occupancy %0d",
                 $time, out_hit, out_read_value, out_occupancy);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_hit);
          mismatch_count++;
        end
        if (out_read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   out_read_value);
          mismatch_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_key_value_cache verification failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases over several capacities.
  initial begin
    lookup_result_t typed_res;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_GET;
    in_key = '0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_capacity = '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
      shadow_rank[i] = '0;
    end
    shadow_count = '0;
    shadow_capacity = CAP_RESET;
    for (int i = 0; i < KEY_POOL; i++)
      key_pool[i] = $urandom;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    gap_pct = 10;
    stall_pct = 10;
    foreach (directed_steps[n]) begin
      if (directed_steps[n].is_cfg) begin
        write_capacity(directed_steps[n].cap);
      end else begin
        typed_res.hit = directed_steps[n].hit;
        typed_res.read_value = directed_steps[n].read_value;
        typed_res.occupancy = directed_steps[n].occupancy;
        send_request(directed_steps[n].cmd, directed_steps[n].key, directed_steps[n].value,
                     directed_steps[n].typed, typed_res);
      end
    end

    // Full capacity, more keys than slots so the cache keeps evicting.
    gap_pct = 15;
    stall_pct = 12;
    run_traffic(150, 24);

    // Inserts disabled; lookups still see what was left behind.
    write_capacity(5'd0);
    gap_pct = 0;
    stall_pct = 0;
    run_traffic(30, 24);

    // A single slot.
    write_capacity(5'd1);
    gap_pct = 20;
    stall_pct = 20;
    run_traffic(50, 4);

    // Capacity above the slot count, with a long result hold-off to back up the input.
    write_capacity(5'd31);
    gap_pct = 8;
    stall_pct = 8;
    hold_request = 1'b1;
    run_traffic(100, 20);

    // Capacity lowered under the current occupancy.
    write_capacity(5'd3);
    gap_pct = 12;
    stall_pct = 12;
    run_traffic(60, 8);

    write_capacity(5'd16);
    gap_pct = 15;
    stall_pct = 15;
    run_traffic(100, 20);

    // Last stretch at a random capacity, no idling on either side.
    write_capacity(5'($urandom_range(0, 31)));
    gap_pct = 0;
    stall_pct = 0;
    run_traffic(60, 20);

    in_valid = 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("lru_key_value_cache verification clean");
    else
      $display("lru_key_value_cache verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lkv_pkg.sv
hdl/lkv_cell.sv
hdl/lru_key_value_cache.sv
tb/tb.sv
